### src/rol_pkg.sv
// ----------------------------------------------------------------------------
// rol_pkg
// Shared types and constants for the ordered record list.
// ----------------------------------------------------------------------------
package rol_pkg;

   // List capacity in records
   localparam int LIST_DEPTH = 16;

   // Fixed field widths
   localparam int POS_W = 4;
   localparam int KEY_W = 64;
   localparam int PAY_W = 64;
   localparam int LEN_W = 5;

   // Derived widths: entry count, entry index, and a compare width wide
   // enough for both position and count plus a spare bit
   localparam int CNT_W = $clog2(LIST_DEPTH + 1);
   localparam int IDX_W = $clog2(LIST_DEPTH);
   localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_CHANGE = 2'd2,
      CMD_QUERY  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_POS   = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic {
      CTL_IDLE = 1'b0,
      CTL_EXEC = 1'b1
   } ctl_state_type;

   typedef logic [POS_W-1:0] pos_type;
   typedef logic [KEY_W-1:0] key_type;
   typedef logic [PAY_W-1:0] pay_type;
   typedef logic [LEN_W-1:0] len_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load_req;   // capture the request fields
      logic execute;    // apply the operation and load the result register
   } ctl_cmd_type;

endpackage

### src/rol_req_if.sv
// ----------------------------------------------------------------------------
// rol_req_if
// Request channel: one list command per transfer.
// ----------------------------------------------------------------------------
interface rol_req_if;
   logic               valid;
   logic               ready;
   rol_pkg::cmd_type   cmd;
   rol_pkg::pos_type   position;
   rol_pkg::key_type   record_key;
   rol_pkg::pay_type   record_payload;

   modport source (output valid, output cmd, output position, output record_key,
                   output record_payload, input ready);
   modport sink   (input valid, input cmd, input position, input record_key,
                   input record_payload, output ready);
endinterface

### src/rol_rsp_if.sv
// ----------------------------------------------------------------------------
// rol_rsp_if
// Response channel: one result per command.
// ----------------------------------------------------------------------------
interface rol_rsp_if;
   logic                 valid;
   logic                 ready;
   rol_pkg::status_type  status;
   rol_pkg::pos_type     found_position;
   rol_pkg::len_type     list_length;

   modport source (output valid, output status, output found_position,
                   output list_length, input ready);
   modport sink   (input valid, input status, input found_position,
                   input list_length, output ready);
endinterface

### src/rol_ctrl.sv
// ----------------------------------------------------------------------------
// rol_ctrl
// Handshake controller: captures a request, then executes it once the
// result register is free.
// ----------------------------------------------------------------------------
module rol_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rol_pkg::ctl_cmd_type  cmd
);
   import rol_pkg::*;

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          exec_go;

   // Result register can take a new value when empty or being drained
   assign exec_go = (state_ff == CTL_EXEC) && (!rsp_valid_ff || rsp_ready);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CTL_IDLE: begin
            if (req_valid) state_in = CTL_EXEC;
         end
         CTL_EXEC: begin
            if (exec_go) state_in = CTL_IDLE;
         end
         default: state_in = CTL_IDLE;
      endcase
   end

   // Outputs and result-valid tracking
   always_comb begin
      req_ready    = (state_ff == CTL_IDLE);
      cmd.load_req = req_valid && (state_ff == CTL_IDLE);
      cmd.execute  = exec_go;
      rsp_valid    = rsp_valid_ff;
      if (exec_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### src/rol_datapath.sv
// ----------------------------------------------------------------------------
// rol_datapath
// Record register row with parallel shift, overwrite and key match, plus
// the request and result registers.
// ----------------------------------------------------------------------------
module rol_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  rol_pkg::ctl_cmd_type  cmd,
   input  rol_pkg::cmd_type      req_cmd,
   input  rol_pkg::pos_type      req_position,
   input  rol_pkg::key_type      req_key,
   input  rol_pkg::pay_type      req_payload,
   output rol_pkg::status_type   rsp_status,
   output rol_pkg::pos_type      rsp_found_position,
   output rol_pkg::len_type      rsp_list_length
);
   import rol_pkg::*;

   // Captured request
   cmd_type      op_ff;
   pos_type      pos_ff;
   key_type      key_ff;
   pay_type      pay_ff;

   // Record row and entry count
   key_type      keys_ff [LIST_DEPTH];
   key_type      keys_in [LIST_DEPTH];
   pay_type      pays_ff [LIST_DEPTH];
   pay_type      pays_in [LIST_DEPTH];
   logic [CNT_W-1:0] count_ff, count_in;

   // Result register
   status_type   status_ff, status_in;
   pos_type      found_ff, found_in;
   len_type      len_ff, len_in;

   logic [CMP_W-1:0] pos_cmp, count_cmp, ins_at;
   logic [LIST_DEPTH-1:0] hit;
   logic [IDX_W-1:0] hit_idx;

   assign pos_cmp   = CMP_W'(pos_ff);
   assign count_cmp = CMP_W'(count_ff);
   // Insert past the end appends
   assign ins_at    = (pos_cmp > count_cmp) ? count_cmp : pos_cmp;

   // Key match against every live entry, lowest position wins
   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         hit[i] = (CMP_W'(i) < count_cmp) && (keys_ff[i] == key_ff);
      end
      for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
         if (hit[i]) hit_idx = IDX_W'(i);
      end
   end

   // Operation decode and row update
   always_comb begin
      keys_in   = keys_ff;
      pays_in   = pays_ff;
      count_in  = count_ff;
      status_in = ST_OK;
      found_in  = '0;
      case (op_ff)
         CMD_INSERT: begin
            if (pos_cmp >= CMP_W'(LIST_DEPTH)) begin
               status_in = ST_BAD_POS;
            end else if (count_cmp >= CMP_W'(LIST_DEPTH)) begin
               status_in = ST_FULL;
            end else begin
               for (int i = 1; i < LIST_DEPTH; i++) begin
                  if ((CMP_W'(i) > ins_at) && (CMP_W'(i) <= count_cmp)) begin
                     keys_in[i] = keys_ff[i-1];
                     pays_in[i] = pays_ff[i-1];
                  end
               end
               keys_in[ins_at[IDX_W-1:0]] = key_ff;
               pays_in[ins_at[IDX_W-1:0]] = pay_ff;
               count_in = count_ff + CNT_W'(1);
            end
         end
         CMD_DELETE: begin
            if (pos_cmp >= count_cmp) begin
               status_in = ST_BAD_POS;
            end else begin
               for (int i = 0; i < LIST_DEPTH - 1; i++) begin
                  if ((CMP_W'(i) >= pos_cmp) && (CMP_W'(i + 1) < count_cmp)) begin
                     keys_in[i] = keys_ff[i+1];
                     pays_in[i] = pays_ff[i+1];
                  end
               end
               count_in = count_ff - CNT_W'(1);
            end
         end
         CMD_CHANGE: begin
            if (pos_cmp >= count_cmp) begin
               status_in = ST_BAD_POS;
            end else begin
               keys_in[pos_cmp[IDX_W-1:0]] = key_ff;
               pays_in[pos_cmp[IDX_W-1:0]] = pay_ff;
            end
         end
         CMD_QUERY: begin
            if (|hit) begin
               found_in = POS_W'(hit_idx);
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         default: status_in = ST_OK;
      endcase
      len_in = LEN_W'(count_in);
   end

   // Request capture, record row and result register (no reset needed)
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff  <= req_cmd;
         pos_ff <= req_position;
         key_ff <= req_key;
         pay_ff <= req_payload;
      end
      if (cmd.execute) begin
         keys_ff   <= keys_in;
         pays_ff   <= pays_in;
         status_ff <= status_in;
         found_ff  <= found_in;
         len_ff    <= len_in;
      end
   end

   // Entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.execute) begin
         count_ff <= count_in;
      end
   end

   assign rsp_status         = status_ff;
   assign rsp_found_position = found_ff;
   assign rsp_list_length    = len_ff;

endmodule

### src/ordered_record_list_unit.sv
// ----------------------------------------------------------------------------
// ordered_record_list_unit
// Fixed-depth ordered list of key/payload records with insert, delete,
// change and query-by-key commands.
//
//   channel    dir  payload                                   flow
//   req_chan   in   cmd, position, record_key, record_payload  valid/ready
//   rsp_chan   out  status, found_position, list_length        valid/ready
//
// A command is captured at its transfer and executed in the EXEC state, which
// loads its result into the result register; no new request is taken until then.
// The next request is taken while an earlier result still waits.
// Execution holds while the result register is full and not being drained.
// Synchronous reset empties the list; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ordered_record_list_unit (
   input  logic       clock,
   input  logic       reset,
   rol_req_if.sink    req_chan,
   rol_rsp_if.source  rsp_chan
);
   import rol_pkg::*;

   ctl_cmd_type ctl_cmd;

   rol_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (ctl_cmd)
   );

   rol_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (ctl_cmd),
      .req_cmd            (req_chan.cmd),
      .req_position       (req_chan.position),
      .req_key            (req_chan.record_key),
      .req_payload        (req_chan.record_payload),
      .rsp_status         (rsp_chan.status),
      .rsp_found_position (rsp_chan.found_position),
      .rsp_list_length    (rsp_chan.list_length)
   );

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ordered record list. A scoreboard keeps its own
// copy of the list, works out the status, match position and length of every
// accepted command, and compares them in order with the returned results.
// Directed commands cover the edge cases, then random fill/drain traffic with
// bursty idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
   import rol_pkg::*;

   localparam int NUM_RANDOM  = 1800;
   localparam int CALM_ITEMS  = 200;    // final items sent with no idling
   localparam int HOLD_CYCLES = 300;    // long receiver hold-off
   localparam int STALL_LIMIT = 4000;   // cycles with no transfer at all
   localparam int SHOW_LIMIT  = 100;    // mismatch lines printed at most

   typedef struct packed {
      status_type status;
      pos_type    found_position;
      len_type    list_length;
   } list_result_type;

   // Scoreboard: shadow list plus queue of expected results
   class list_scoreboard;
      key_type         keys [LIST_DEPTH];
      pay_type         pays [LIST_DEPTH];
      int              count;
      list_result_type expected_q[$];
      int              errors;
      int              shown;

      function new();
         count  = 0;
         errors = 0;
         shown  = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Apply one accepted command to the shadow list
      function void note_request(cmd_type c, pos_type p, key_type k, pay_type d);
         list_result_type r;
         int              at;
         bit              hit;
         r.status         = ST_OK;
         r.found_position = '0;
         hit              = 0;
         case (c)
            CMD_INSERT: begin
               if (int'(p) >= LIST_DEPTH) begin
                  r.status = ST_BAD_POS;
               end else if (count >= LIST_DEPTH) begin
                  r.status = ST_FULL;
               end else begin
                  // position past the end appends
                  at = (int'(p) > count) ? count : int'(p);
                  for (int i = count; i > at; i--) begin
                     keys[i] = keys[i-1];
                     pays[i] = pays[i-1];
                  end
                  keys[at] = k;
                  pays[at] = d;
                  count++;
               end
            end
            CMD_DELETE: begin
               if (int'(p) >= count) begin
                  r.status = ST_BAD_POS;
               end else begin
                  for (int i = int'(p); i + 1 < count; i++) begin
                     keys[i] = keys[i+1];
                     pays[i] = pays[i+1];
                  end
                  count--;
                  keys[count] = '0;
                  pays[count] = '0;
               end
            end
            CMD_CHANGE: begin
               if (int'(p) >= count) begin
                  r.status = ST_BAD_POS;
               end else begin
                  keys[p] = k;
                  pays[p] = d;
               end
            end
            default: begin
               // first matching key wins; empty list is a miss
               r.status = ST_NOT_FOUND;
               for (int i = 0; i < count; i++) begin
                  if (!hit && keys[i] == k) begin
                     hit              = 1;
                     r.status         = ST_OK;
                     r.found_position = pos_type'(i);
                  end
               end
            end
         endcase
         r.list_length = len_type'(count);
         expected_q.push_back(r);
      endfunction

      // Compare one result transfer with the oldest expectation
      function void check_result(status_type s, pos_type f, len_type l);
         list_result_type e;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result status %0d pos %0d len %0d",
                     $time, s, f, l);
            return;
         end
         e = expected_q.pop_front();
         if (s !== e.status) begin
            errors++;
            if (shown++ < SHOW_LIMIT)
               $display("%0t: status expected %0d got %0d", $time, e.status, s);
         end
         if (f !== e.found_position) begin
            errors++;
            if (shown++ < SHOW_LIMIT)
               $display("%0t: found_position expected %0d got %0d",
                        $time, e.found_position, f);
         end
         if (l !== e.list_length) begin
            errors++;
            if (shown++ < SHOW_LIMIT)
               $display("%0t: list_length expected %0d got %0d",
                        $time, e.list_length, l);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   rol_req_if req_chan ();
   rol_rsp_if rsp_chan ();

   list_scoreboard sb;
   key_type        key_pool [8];
   bit             hold_request = 0;   // ask the receiver for a long hold-off
   bit             hold_active  = 0;
   bit             calm         = 0;   // no idling on either side
   int             idle_cycles  = 0;

   ordered_record_list_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #4 clock = ~clock;

   // Offer one command and wait for its transfer
   task automatic send_item(input cmd_type c, input pos_type p,
                            input key_type k, input pay_type d);
      req_chan.valid          <= 1'b1;
      req_chan.cmd            <= c;
      req_chan.position       <= p;
      req_chan.record_key     <= k;
      req_chan.record_payload <= d;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_request(c, p, k, d);
   endtask

   // Drop valid for a few cycles
   task automatic sender_gap(input int cycles);
      req_chan.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Result checking
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_result(rsp_chan.status, rsp_chan.found_position,
                         rsp_chan.list_length);
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side ready: bursts of stall, long hold-off on request
   initial begin
      rsp_chan.ready = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 0;
            hold_active  = 1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_active  = 0;
         end else if (!calm && $urandom_range(0, 99) < 20) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 80 : 20))
               @(posedge clock);
         end
      end
   end

   // Stimulus
   initial begin
      bit      growing;
      bit      sender_idles;
      int      roll;
      int      ins_pct;
      int      del_pct;
      cmd_type c;
      pos_type p;
      key_type k;
      pay_type d;

      sb = new();
      foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
      req_chan.valid          = 1'b0;
      req_chan.cmd            = CMD_QUERY;
      req_chan.position       = '0;
      req_chan.record_key     = '0;
      req_chan.record_payload = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty list, appends, front/middle inserts, duplicates,
      // first-match query, bad positions, deletes at top/front/middle
      send_item(CMD_QUERY,  4'd0,  64'd0, 64'd0);
      send_item(CMD_DELETE, 4'd0,  64'd0, 64'd0);
      send_item(CMD_CHANGE, 4'd0,  64'h1, 64'h1);
      send_item(CMD_INSERT, 4'd15, '1, '1);
      send_item(CMD_INSERT, 4'd0,  64'd0, 64'd0);
      send_item(CMD_INSERT, 4'd1,  64'hA5A5_0F0F_3C3C_9696, 64'h0123_4567_89AB_CDEF);
      send_item(CMD_INSERT, 4'd3,  '1, 64'h5);
      send_item(CMD_QUERY,  4'd7,  '1, 64'd0);
      send_item(CMD_QUERY,  4'd0,  64'd0, '1);
      send_item(CMD_QUERY,  4'd15, 64'hA5A5_0F0F_3C3C_9696, 64'd0);
      send_item(CMD_QUERY,  4'd0,  64'h5A5A_F0F0_C3C3_6969, 64'd0);
      send_item(CMD_CHANGE, 4'd3,  64'h5A5A_F0F0_C3C3_6969, '1);
      send_item(CMD_CHANGE, 4'd4,  64'h7, 64'h7);
      send_item(CMD_CHANGE, 4'd15, 64'h7, 64'h7);
      send_item(CMD_QUERY,  4'd0,  64'h5A5A_F0F0_C3C3_6969, 64'd0);
      send_item(CMD_DELETE, 4'd3,  64'd0, 64'd0);
      send_item(CMD_DELETE, 4'd0,  64'd0, 64'd0);
      send_item(CMD_INSERT, 4'd1,  64'h8000_0000_0000_0001, 64'd0);
      send_item(CMD_DELETE, 4'd1,  64'd0, 64'd0);
      send_item(CMD_DELETE, 4'd5,  64'd0, 64'd0);
      send_item(CMD_QUERY,  4'd0,  64'h8000_0000_0000_0001, 64'd0);

      // Random fill/drain traffic
      growing      = 1;
      sender_idles = 1;
      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n % 100 == 0) sender_idles = ($urandom_range(0, 3) != 0);
         if (n == NUM_RANDOM - CALM_ITEMS) calm = 1;
         if (n == 400) hold_request = 1;

         // once, drain everything before going on
         if (n == 900) begin
            req_chan.valid <= 1'b0;
            do @(posedge clock); while (sb.pending() != 0);
         end else if (!calm && !hold_active && sender_idles &&
                      $urandom_range(0, 4) == 0) begin
            sender_gap($urandom_range(1, 12));
         end

         // stay full for a few commands before draining
         if (sb.count == LIST_DEPTH && $urandom_range(0, 3) == 0) growing = 0;
         if (sb.count == 0) growing = 1;
         ins_pct = growing ? 55 : 8;
         del_pct = growing ? 8 : 55;
         roll    = $urandom_range(0, 99);
         if (roll < ins_pct)                c = CMD_INSERT;
         else if (roll < ins_pct + del_pct) c = CMD_DELETE;
         else if (roll < ins_pct + del_pct + 15) c = CMD_CHANGE;
         else                               c = CMD_QUERY;

         // mostly valid positions, some anywhere in the field
         if (sb.count == 0 || $urandom_range(0, 4) == 0)
            p = pos_type'($urandom_range(0, 15));
         else if (c == CMD_INSERT)
            p = pos_type'($urandom_range(0, (sb.count < 15) ? sb.count : 15));
         else
            p = pos_type'($urandom_range(0, sb.count - 1));

         // keys from a small pool so queries hit and duplicates appear
         roll = $urandom_range(0, 9);
         if (c == CMD_QUERY && sb.count > 0 && roll < 5)
            k = sb.keys[$urandom_range(0, sb.count - 1)];
         else if (roll < 6)
            k = key_pool[$urandom_range(0, 7)];
         else if (roll == 6)
            k = '0;
         else if (roll == 7)
            k = '1;
         else
            k = {$urandom, $urandom};

         roll = $urandom_range(0, 9);
         d = (roll == 0) ? '0 : (roll == 1) ? '1 : {$urandom, $urandom};

         send_item(c, p, k, d);
      end

      // Drain and let any stray result show up
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (8) @(posedge clock);
      if (sb.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

### files.f
src/rol_pkg.sv
src/rol_req_if.sv
src/rol_rsp_if.sv
src/rol_ctrl.sv
src/rol_datapath.sv
src/ordered_record_list_unit.sv
sim/testbench.sv
